>>> sv/hltc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hltc_pkg;

  // Character codes the recognizers look for.
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChTick   = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChLowS   = 8'h73;
  localparam logic [7:0] ChLowH   = 8'h68;
  localparam logic [7:0] ChLowD   = 8'h64;
  localparam logic [7:0] ChLowO   = 8'h6f;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowP   = 8'h70;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLowM   = 8'h6d;

  // Time-number recognizer states.
  typedef enum logic [2:0] {
    TN_START = 3'd0,
    TN_INT   = 3'd1,
    TN_DOT   = 3'd2,
    TN_FRAC  = 3'd3,
    TN_DEAD  = 3'd4
  } tn_state_e;

  // Real-literal recognizer states.
  typedef enum logic [3:0] {
    RL_START   = 4'd0,
    RL_SIGN    = 4'd1,
    RL_INT     = 4'd2,
    RL_DOTONLY = 4'd3,
    RL_FRAC    = 4'd4,
    RL_EXP     = 4'd5,
    RL_EXPSIGN = 4'd6,
    RL_EXPDIG  = 4'd7,
    RL_DEAD    = 4'd8
  } rl_state_e;

  // Sized-literal prefix recognizer states.
  typedef enum logic [2:0] {
    SZ_DIGITS  = 3'd0,
    SZ_QUOTE   = 3'd1,
    SZ_SIGNED  = 3'd2,
    SZ_BASE    = 3'd3,
    SZ_MATCHED = 3'd4,
    SZ_DEAD    = 3'd5
  } sz_state_e;

  // Token classes, in priority order.
  typedef enum logic [2:0] {
    CLS_TIME    = 3'd0,
    CLS_REAL    = 3'd1,
    CLS_NUMERIC = 3'd2,
    CLS_STRING  = 3'd3,
    CLS_IDENT   = 3'd4
  } token_class_e;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= ChLowA) && (c <= ChLowF)) || ((c >= ChUpA) && (c <= ChUpF));
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == ChPlus) || (c == ChMinus);
  endfunction

  function automatic logic is_e(input logic [7:0] c);
    return (c == ChLowE) || (c == ChUpE);
  endfunction

  function automatic logic is_base(input logic [7:0] c);
    return (c == ChLowH) || (c == ChLowD) || (c == ChLowO) || (c == ChLowB);
  endfunction

  // Characters that can open a two-letter time unit.
  function automatic logic is_unit_lead(input logic [7:0] c);
    return (c == ChLowF) || (c == ChLowP) || (c == ChLowN) || (c == ChLowU) ||
           (c == ChLowM);
  endfunction

  function automatic logic timenum_ok(input tn_state_e st);
    return (st == TN_INT) || (st == TN_FRAC);
  endfunction

  function automatic tn_state_e timenum_next(input tn_state_e st, input logic [7:0] c);
    tn_state_e nx;
    unique case (st)
      TN_START: nx = is_dig(c) ? TN_INT : TN_DEAD;
      TN_INT:   nx = is_dig(c) ? TN_INT : ((c == ChDot) ? TN_DOT : TN_DEAD);
      TN_DOT:   nx = is_dig(c) ? TN_FRAC : TN_DEAD;
      TN_FRAC:  nx = is_dig(c) ? TN_FRAC : TN_DEAD;
      default:  nx = TN_DEAD;
    endcase
    return nx;
  endfunction

  function automatic rl_state_e real_next(input rl_state_e st, input logic [7:0] c);
    rl_state_e nx;
    unique case (st)
      RL_START: begin
        if (is_sign(c))        nx = RL_SIGN;
        else if (is_dig(c))    nx = RL_INT;
        else if (c == ChDot)   nx = RL_DOTONLY;
        else                   nx = RL_DEAD;
      end
      RL_SIGN: begin
        if (is_dig(c))         nx = RL_INT;
        else if (c == ChDot)   nx = RL_DOTONLY;
        else                   nx = RL_DEAD;
      end
      RL_INT: begin
        if (is_dig(c))         nx = RL_INT;
        else if (c == ChDot)   nx = RL_FRAC;
        else if (is_e(c))      nx = RL_EXP;
        else                   nx = RL_DEAD;
      end
      RL_DOTONLY: nx = is_dig(c) ? RL_FRAC : RL_DEAD;
      RL_FRAC: begin
        if (is_dig(c))         nx = RL_FRAC;
        else if (is_e(c))      nx = RL_EXP;
        else                   nx = RL_DEAD;
      end
      RL_EXP: begin
        if (is_sign(c))        nx = RL_EXPSIGN;
        else if (is_dig(c))    nx = RL_EXPDIG;
        else                   nx = RL_DEAD;
      end
      RL_EXPSIGN, RL_EXPDIG: nx = is_dig(c) ? RL_EXPDIG : RL_DEAD;
      default: nx = RL_DEAD;
    endcase
    return nx;
  endfunction

  function automatic sz_state_e sized_next(input sz_state_e st, input logic [7:0] c);
    sz_state_e nx;
    unique case (st)
      SZ_DIGITS:  nx = is_dig(c) ? SZ_DIGITS : ((c == ChTick) ? SZ_QUOTE : SZ_DEAD);
      SZ_QUOTE:   nx = (c == ChLowS) ? SZ_SIGNED : (is_base(c) ? SZ_BASE : SZ_DEAD);
      SZ_SIGNED:  nx = is_base(c) ? SZ_BASE : SZ_DEAD;
      SZ_BASE:    nx = is_hex(c) ? SZ_MATCHED : SZ_DEAD;
      SZ_MATCHED: nx = SZ_MATCHED;
      default:    nx = SZ_DEAD;
    endcase
    return nx;
  endfunction

endpackage

`default_nettype wire

>>> sv/hltc_recog.sv
`timescale 1ns / 1ps
`default_nettype none

// Recognizer state for the token in progress, plus the class decision on
// the character that closes it.
module hltc_recog (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [7:0]            char_code_i,
  input  wire logic                  is_last_i,
  output hltc_pkg::token_class_e     token_class_o
);

  logic [1:0]          char_count_q, char_count_d;
  hltc_pkg::tn_state_e tn_now_q, tn_now_d;
  hltc_pkg::tn_state_e tn_lag_q, tn_lag_d;
  hltc_pkg::rl_state_e real_q, real_d;
  logic                digits_only_q, digits_only_d;
  hltc_pkg::sz_state_e sized_q, sized_d;
  logic                starts_quote_q, starts_quote_d;
  logic [7:0]          cur_char_q, cur_char_d;

  // Values every recognizer takes after the incoming character.
  logic [1:0]          count_next;
  hltc_pkg::tn_state_e tn_next;
  hltc_pkg::rl_state_e real_next;
  logic                digits_next;
  hltc_pkg::sz_state_e sized_next;
  logic                quote_next;
  logic                time_hit;
  logic                two_letter;

  always_comb begin
    count_next  = (char_count_q == 2'd3) ? 2'd3 : char_count_q + 2'd1;
    tn_next     = hltc_pkg::timenum_next(tn_now_q, char_code_i);
    real_next   = hltc_pkg::real_next(real_q, char_code_i);
    digits_next = digits_only_q & hltc_pkg::is_dig(char_code_i);
    sized_next  = hltc_pkg::sized_next(sized_q, char_code_i);
    quote_next  = starts_quote_q |
                  ((char_count_q == 2'd0) && (char_code_i == hltc_pkg::ChDquote));
  end

  // Time literal: the number must end just before the unit. With the new
  // character taken in, the previous character is cur_char_q, the number
  // without the last character is tn_now_q, and without two is tn_lag_q.
  always_comb begin
    two_letter = (count_next == 2'd3) && hltc_pkg::is_unit_lead(cur_char_q);
    time_hit   = 1'b0;
    if (char_code_i == hltc_pkg::ChLowS) begin
      if (two_letter)                time_hit = hltc_pkg::timenum_ok(tn_lag_q);
      else if (count_next >= 2'd2)   time_hit = hltc_pkg::timenum_ok(tn_now_q);
    end
  end

  // Pick the first class that matched.
  always_comb begin
    if (time_hit) begin
      token_class_o = hltc_pkg::CLS_TIME;
    end else if ((real_next == hltc_pkg::RL_FRAC) || (real_next == hltc_pkg::RL_EXPDIG)) begin
      token_class_o = hltc_pkg::CLS_REAL;
    end else if (digits_next || (sized_next == hltc_pkg::SZ_MATCHED)) begin
      token_class_o = hltc_pkg::CLS_NUMERIC;
    end else if (quote_next) begin
      token_class_o = hltc_pkg::CLS_STRING;
    end else begin
      token_class_o = hltc_pkg::CLS_IDENT;
    end
  end

  // State update: advance on each transaction, return to start after the
  // last character of a token.
  always_comb begin
    char_count_d   = char_count_q;
    tn_now_d       = tn_now_q;
    tn_lag_d       = tn_lag_q;
    real_d         = real_q;
    digits_only_d  = digits_only_q;
    sized_d        = sized_q;
    starts_quote_d = starts_quote_q;
    cur_char_d     = cur_char_q;
    if (accept_i) begin
      if (is_last_i) begin
        char_count_d   = 2'd0;
        tn_now_d       = hltc_pkg::TN_START;
        tn_lag_d       = hltc_pkg::TN_START;
        real_d         = hltc_pkg::RL_START;
        digits_only_d  = 1'b1;
        sized_d        = hltc_pkg::SZ_DIGITS;
        starts_quote_d = 1'b0;
        cur_char_d     = 8'd0;
      end else begin
        char_count_d   = count_next;
        tn_now_d       = tn_next;
        tn_lag_d       = tn_now_q;
        real_d         = real_next;
        digits_only_d  = digits_next;
        sized_d        = sized_next;
        starts_quote_d = quote_next;
        cur_char_d     = char_code_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q   <= 2'd0;
      tn_now_q       <= hltc_pkg::TN_START;
      tn_lag_q       <= hltc_pkg::TN_START;
      real_q         <= hltc_pkg::RL_START;
      digits_only_q  <= 1'b1;
      sized_q        <= hltc_pkg::SZ_DIGITS;
      starts_quote_q <= 1'b0;
      cur_char_q     <= 8'd0;
    end else begin
      char_count_q   <= char_count_d;
      tn_now_q       <= tn_now_d;
      tn_lag_q       <= tn_lag_d;
      real_q         <= real_d;
      digits_only_q  <= digits_only_d;
      sized_q        <= sized_d;
      starts_quote_q <= starts_quote_d;
      cur_char_q     <= cur_char_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/hdl_literal_token_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Classifies one HDL token fed one character per transaction, the final
// character flagged by is_last_i. Each accepted character updates the
// recognizer state, and a new one can follow in the next cycle; the class
// of a token (0 time, 1 real, 2 numeric, 3 string, 4 identifier) is held
// in the output register from the cycle after its final character is
// accepted. The input stalls only while that register holds a result the
// downstream side is stalling. Non-final characters produce no result.
module hdl_literal_token_classifier_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       is_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      token_class_o
);

  logic                     accept;
  hltc_pkg::token_class_e   class_now;
  logic                     out_valid_q, out_valid_d;
  logic [2:0]               token_class_q, token_class_d;

  // Input transactions proceed unless the result register is blocked.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  hltc_recog u_recog (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .is_last_i     (is_last_i),
    .token_class_o (class_now)
  );

  // Result register: load on a final character, drain when taken.
  always_comb begin
    out_valid_d   = out_valid_q;
    token_class_d = token_class_q;
    if (accept && is_last_i) begin
      out_valid_d   = 1'b1;
      token_class_d = class_now;
    end else if (!out_stall_i) begin
      out_valid_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    token_class_q <= token_class_d;
  end

  assign out_valid_o   = out_valid_q;
  assign token_class_o = token_class_q;

endmodule

`default_nettype wire
